>>> rtl/smm_pkg.sv
`timescale 1ns / 1ps
package smm_pkg;
    localparam int MAX_DIM_DEF = 16;
    localparam logic [1:0] KIND_WR_A = 2'd0;
    localparam logic [1:0] KIND_WR_B = 2'd1;
    localparam logic [1:0] KIND_COMP = 2'd2;
    localparam logic [1:0] KIND_RD_C = 2'd3;
    localparam logic [3:0] HALF_RESET = 4'd8;
endpackage

>>> rtl/smm_mem.sv
`timescale 1ns / 1ps
module smm_mem #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/strassen_block_matrix_multiply_top.sv
`timescale 1ns / 1ps
// Writes of A or B: one transaction per cycle while out_ready holds, result the cycle after acceptance.
// Reads of C: the C word passes through rd_pend_reg, then out_reg; input held off while rd_pend_reg is set.
// Compute: each multiply-accumulate steps through ST_RD0, ST_RD1 and ST_MAC: two reads of the
// single A and B ports per operand, then the operand register.
// Assembly of C: per element seven product reads, a turnaround and four C writes.
// Reset (rst_n, async low) clears control and sets half_size to 8; memories are not cleared.
module strassen_block_matrix_multiply_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [3:0]  row,
    input  logic [3:0]  col,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] result_value
);
    localparam int MAX_DIM = smm_pkg::MAX_DIM_DEF;
    localparam int HM = MAX_DIM / 2;
    localparam int DW = $clog2(MAX_DIM);
    localparam int HW = $clog2(HM + 1);
    localparam int SAW = 2 * DW;
    localparam int PD = 7 * HM * HM;
    localparam int PAW = $clog2(PD);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_MAC  = 3'd3;
    localparam logic [2:0] ST_AS   = 3'd4;
    localparam logic [2:0] ST_ASW  = 3'd5;

    logic [3:0] half_reg;
    logic [2:0] st_reg;
    logic [HW-1:0] h;
    logic [2:0] p_reg;
    logic [DW-1:0] i_reg, j_reg, k_reg;
    logic [2:0] m_reg;
    logic [31:0] acc_reg, x0_reg, y0_reg, opa_reg, opb_reg;
    logic        mac_v_reg;
    logic [31:0] m_sav [7];
    logic        rd_pend_reg;
    logic [31:0] out_reg;
    logic        out_v_reg;

    // effective quadrant size: zero means one, clamp to half of the store
    always_comb
    begin
        if (half_reg == 4'd0)
            h = HW'(1);
        else if (32'(half_reg) > HM)
            h = HW'(HM);
        else
            h = HW'(half_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= smm_pkg::HALF_RESET;
        else if (cfg_we)
            half_reg <= cfg_wdata;
    end

    logic acc_in;
    logic in_store;
    assign acc_in = in_valid && in_ready;
    assign in_store = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    assign in_ready = (st_reg == ST_IDLE) && !rd_pend_reg && (!out_v_reg || out_ready);

    // quadrant selection for the two words of each operand
    logic [1:0] qa0, qa1, qb0, qb1;
    logic       a_two, b_two, a_sub, b_sub;
    always_comb
    begin
        qa0 = 2'd0; qa1 = 2'd3; a_two = 1'b1; a_sub = 1'b0;
        qb0 = 2'd0; qb1 = 2'd3; b_two = 1'b1; b_sub = 1'b0;
        case (p_reg)
            3'd0: begin end
            3'd1:
            begin
                qa0 = 2'd2; qb1 = 2'd0; b_two = 1'b0;
            end
            3'd2:
            begin
                qa1 = 2'd0; a_two = 1'b0; qb0 = 2'd1; b_sub = 1'b1;
            end
            3'd3:
            begin
                qa0 = 2'd3; a_two = 1'b0; qb0 = 2'd2; qb1 = 2'd0; b_sub = 1'b1;
            end
            3'd4:
            begin
                qa1 = 2'd1; qb0 = 2'd3; b_two = 1'b0;
            end
            3'd5:
            begin
                qa0 = 2'd2; qa1 = 2'd0; a_sub = 1'b1; qb1 = 2'd1;
            end
            default:
            begin
                qa0 = 2'd1; a_sub = 1'b1; qb0 = 2'd2;
            end
        endcase
    end

    function automatic logic [SAW-1:0] qaddr(input logic [1:0] q, input logic [DW-1:0] r,
                                               input logic [DW-1:0] c, input logic [HW-1:0] hh);
        logic [DW:0] rr;
        logic [DW:0] cc;
        begin
            rr = (DW+1)'(r) + (q[1] ? (DW+1)'(hh) : '0);
            cc = (DW+1)'(c) + (q[0] ? (DW+1)'(hh) : '0);
            qaddr = {rr[DW-1:0], cc[DW-1:0]};
        end
    endfunction

    // memory ports
    logic [SAW-1:0] a_ra, b_ra, c_wa, c_ra;
    logic [31:0]    a_rd, b_rd, c_rd, c_wd, p_rd, p_wd;
    logic           a_we, b_we, c_we, p_we;
    logic [PAW-1:0] p_wa, p_ra;
    logic [PAW-1:0] pbase;

    assign pbase = PAW'(32'(i_reg) * HM + 32'(j_reg));

    always_comb
    begin
        a_ra = qaddr(st_reg == ST_RD0 ? qa0 : qa1, i_reg, k_reg, h);
        b_ra = qaddr(st_reg == ST_RD0 ? qb0 : qb1, k_reg, j_reg, h);
        c_ra = {row[DW-1:0], col[DW-1:0]};
        p_ra = PAW'(32'(m_reg) * HM * HM + 32'(pbase));
    end

    assign a_we = acc_in && kind == smm_pkg::KIND_WR_A && in_store;
    assign b_we = acc_in && kind == smm_pkg::KIND_WR_B && in_store;

    smm_mem #(.DEPTH(MAX_DIM*MAX_DIM), .AW(SAW)) u_a (
        .clk(clk), .we(a_we), .waddr({row[DW-1:0], col[DW-1:0]}), .wdata(value),
        .raddr(a_ra), .rdata(a_rd));
    smm_mem #(.DEPTH(MAX_DIM*MAX_DIM), .AW(SAW)) u_b (
        .clk(clk), .we(b_we), .waddr({row[DW-1:0], col[DW-1:0]}), .wdata(value),
        .raddr(b_ra), .rdata(b_rd));
    smm_mem #(.DEPTH(PD), .AW(PAW)) u_p (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
        .raddr(p_ra), .rdata(p_rd));
    smm_mem #(.DEPTH(MAX_DIM*MAX_DIM), .AW(SAW)) u_c (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
        .raddr(c_ra), .rdata(c_rd));

    // operand forming from the two words of each memory
    logic [31:0] opa, opb, prod;
    assign opa = a_two ? (a_sub ? x0_reg - a_rd : x0_reg + a_rd) : x0_reg;
    assign opb = b_two ? (b_sub ? y0_reg - b_rd : y0_reg + b_rd) : y0_reg;
    assign prod = opa_reg * opb_reg;

    logic last_k, last_j, last_i;
    assign last_k = (HW'(k_reg) + HW'(1)) == h;
    assign last_j = (HW'(j_reg) + HW'(1)) == h;
    assign last_i = (HW'(i_reg) + HW'(1)) == h;

    // assembly: the word read during m step arrives next cycle
    logic [2:0] m_prev_reg;
    logic       as_v_reg;
    logic [1:0] cw_reg;
    logic [31:0] m1, m2, m3, m4, m5, m6, m7;
    assign m1 = m_sav[0]; assign m2 = m_sav[1]; assign m3 = m_sav[2];
    assign m4 = m_sav[3]; assign m5 = m_sav[4]; assign m6 = m_sav[5];
    assign m7 = m_sav[6];

    always_comb
    begin
        c_we = 1'b0; c_wa = '0; c_wd = '0;
        if (st_reg == ST_ASW)
        begin
            c_we = 1'b1;
            case (cw_reg)
                2'd0:
                begin
                    c_wa = qaddr(2'd0, i_reg, j_reg, h); c_wd = m1 + m4 - m5 + m7;
                end
                2'd1:
                begin
                    c_wa = qaddr(2'd1, i_reg, j_reg, h); c_wd = m3 + m5;
                end
                2'd2:
                begin
                    c_wa = qaddr(2'd2, i_reg, j_reg, h); c_wd = m2 + m4;
                end
                default:
                begin
                    c_wa = qaddr(2'd3, i_reg, j_reg, h); c_wd = m1 - m2 + m3 + m6;
                end
            endcase
        end
    end

    // the product memory write is the registered end-of-sum strobe
    logic        pw_v_reg;
    logic [PAW-1:0] pw_a_reg;
    logic [31:0] pw_d_reg;
    assign p_we = pw_v_reg;
    assign p_wa = pw_a_reg;
    assign p_wd = pw_d_reg;

    logic mac_last_reg;
    logic [PAW-1:0] mac_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            p_reg <= '0; i_reg <= '0; j_reg <= '0; k_reg <= '0; m_reg <= '0;
            mac_v_reg <= 1'b0; pw_v_reg <= 1'b0; as_v_reg <= 1'b0;
            rd_pend_reg <= 1'b0; out_v_reg <= 1'b0; cw_reg <= '0;
            acc_reg <= '0; mac_last_reg <= 1'b0;
        end
        else
        begin
            pw_v_reg <= 1'b0;
            if (out_v_reg && out_ready)
                out_v_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            if (rd_pend_reg)
            begin
                out_v_reg <= 1'b1;
            end
            if (acc_in)
            begin
                if (kind == smm_pkg::KIND_RD_C)
                    rd_pend_reg <= 1'b1;
                else if (kind == smm_pkg::KIND_COMP)
                begin
                    st_reg <= ST_RD0;
                    p_reg <= '0; i_reg <= '0; j_reg <= '0; k_reg <= '0;
                    acc_reg <= '0;
                end
                else
                    out_v_reg <= 1'b1;
            end
            // multiply-accumulate stage, fed from the operand registers
            mac_v_reg <= 1'b0;
            if (mac_v_reg)
            begin
                if (mac_last_reg)
                begin
                    pw_v_reg <= 1'b1;
                    acc_reg <= '0;
                end
                else
                    acc_reg <= acc_reg + prod;
            end
            case (st_reg)
                ST_RD0:
                begin
                    st_reg <= ST_RD1;
                end
                ST_RD1:
                begin
                    st_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    mac_v_reg <= 1'b1;
                    mac_last_reg <= last_k;
                    mac_addr_reg <= PAW'(32'(p_reg) * HM * HM + 32'(pbase));
                    st_reg <= ST_RD0;
                    if (!last_k)
                        k_reg <= k_reg + DW'(1);
                    else
                    begin
                        k_reg <= '0;
                        if (!last_j)
                            j_reg <= j_reg + DW'(1);
                        else
                        begin
                            j_reg <= '0;
                            if (!last_i)
                                i_reg <= i_reg + DW'(1);
                            else
                            begin
                                i_reg <= '0;
                                if (p_reg != 3'd6)
                                    p_reg <= p_reg + 3'd1;
                                else
                                begin
                                    st_reg <= ST_AS;
                                    m_reg <= '0;
                                    as_v_reg <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_AS:
                begin
                    // wait for the pending product write to land before reading back
                    if (!mac_v_reg && !pw_v_reg)
                    begin
                        as_v_reg <= 1'b1;
                        m_prev_reg <= m_reg;
                        if (as_v_reg)
                            m_sav[m_prev_reg] <= p_rd;
                        if (m_reg != 3'd6)
                            m_reg <= m_reg + 3'd1;
                        else if (as_v_reg && m_prev_reg == 3'd6)
                        begin
                            st_reg <= ST_ASW;
                            cw_reg <= '0;
                        end
                    end
                end
                ST_ASW:
                begin
                    cw_reg <= cw_reg + 2'd1;
                    if (cw_reg == 2'd3)
                    begin
                        m_reg <= '0;
                        as_v_reg <= 1'b0;
                        st_reg <= ST_AS;
                        if (!last_j)
                            j_reg <= j_reg + DW'(1);
                        else
                        begin
                            j_reg <= '0;
                            if (!last_i)
                                i_reg <= i_reg + DW'(1);
                            else
                            begin
                                i_reg <= '0;
                                st_reg <= ST_IDLE;
                                out_v_reg <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // operand capture: first word held, second combined
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_RD1)
        begin
            x0_reg <= a_rd;
            y0_reg <= b_rd;
        end
        if (st_reg == ST_MAC)
        begin
            opa_reg <= opa;
            opb_reg <= opb;
        end
        if (mac_v_reg && mac_last_reg)
        begin
            pw_d_reg <= acc_reg + prod;
            pw_a_reg <= mac_addr_reg;
        end
        if (rd_pend_reg)
            out_reg <= c_rd;
        else if (acc_in && kind != smm_pkg::KIND_RD_C)
            out_reg <= '0;
        else if (st_reg == ST_ASW && cw_reg == 2'd3 && last_i && last_j)
            out_reg <= '0;
    end

    assign out_valid = out_v_reg;
    assign result_value = out_reg;

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_IDLE |-> !in_ready) else $error("accept while computing");
    a_rd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> out_v_reg) else $error("read result lost");
    a_pw_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
        pw_v_reg |-> $past(mac_v_reg)) else $error("product write without mac");
endmodule

>>> dv/strassen_block_matrix_multiply_checker.sv
`timescale 1ns / 1ps
module strassen_block_matrix_multiply_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] result_value,
    output int                 fail_count,
    output int                 pending_count
);
    localparam int DIM = 16;

    logic [3:0]  half_reg;
    logic [31:0] a_mem [DIM*DIM];
    logic [31:0] b_mem [DIM*DIM];
    logic [31:0] c_mem [DIM*DIM];
    logic [31:0] expected_results [$];

    function automatic logic [31:0] quad_word(input bit from_b, input int qr, input int qc,
                                              input int i, input int j, input int h);
        int idx;
        idx = (qr * h + i) * DIM + qc * h + j;
        return from_b ? b_mem[idx] : a_mem[idx];
    endfunction

    function automatic logic [31:0] left_term(input int p, input int i, input int k,
                                              input int h);
        case (p)
            0: return quad_word(0, 0, 0, i, k, h) + quad_word(0, 1, 1, i, k, h);
            1: return quad_word(0, 1, 0, i, k, h) + quad_word(0, 1, 1, i, k, h);
            2: return quad_word(0, 0, 0, i, k, h);
            3: return quad_word(0, 1, 1, i, k, h);
            4: return quad_word(0, 0, 0, i, k, h) + quad_word(0, 0, 1, i, k, h);
            5: return quad_word(0, 1, 0, i, k, h) - quad_word(0, 0, 0, i, k, h);
            default: return quad_word(0, 0, 1, i, k, h) - quad_word(0, 1, 1, i, k, h);
        endcase
    endfunction

    function automatic logic [31:0] right_term(input int p, input int k, input int j,
                                               input int h);
        case (p)
            0: return quad_word(1, 0, 0, k, j, h) + quad_word(1, 1, 1, k, j, h);
            1: return quad_word(1, 0, 0, k, j, h);
            2: return quad_word(1, 0, 1, k, j, h) - quad_word(1, 1, 1, k, j, h);
            3: return quad_word(1, 1, 0, k, j, h) - quad_word(1, 0, 0, k, j, h);
            4: return quad_word(1, 1, 1, k, j, h);
            5: return quad_word(1, 0, 0, k, j, h) + quad_word(1, 0, 1, k, j, h);
            default: return quad_word(1, 1, 0, k, j, h) + quad_word(1, 1, 1, k, j, h);
        endcase
    endfunction

    // Seven quadrant products, then the four C quadrants; all mod 2^32.
    function automatic void form_product(input logic [3:0] hs);
        int h;
        logic [31:0] m [7][8][8];
        logic [31:0] acc;
        logic [31:0] lv;
        logic [31:0] rv;
        h = (hs == 0) ? 1 : ((hs > 8) ? 8 : int'(hs));
        for (int p = 0; p < 7; p++)
            for (int i = 0; i < h; i++)
                for (int j = 0; j < h; j++) begin
                    acc = '0;
                    for (int k = 0; k < h; k++) begin
                        lv = left_term(p, i, k, h);
                        rv = right_term(p, k, j, h);
                        acc = acc + lv * rv;
                    end
                    m[p][i][j] = acc;
                end
        for (int i = 0; i < h; i++)
            for (int j = 0; j < h; j++) begin
                c_mem[i*DIM + j] = m[0][i][j] + m[3][i][j] - m[4][i][j] + m[6][i][j];
                c_mem[i*DIM + h + j] = m[2][i][j] + m[4][i][j];
                c_mem[(h+i)*DIM + j] = m[1][i][j] + m[3][i][j];
                c_mem[(h+i)*DIM + h + j] = m[0][i][j] - m[1][i][j] + m[2][i][j]
                                           + m[5][i][j];
            end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [31:0] want;
        logic [31:0] word;
        if (!rst_n) begin
            half_reg = smm_pkg::HALF_RESET;
            expected_results.delete();
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_we)
                half_reg = cfg_wdata;
            if (in_valid && in_ready) begin
                word = '0;
                case (kind)
                    smm_pkg::KIND_WR_A: a_mem[{row, col}] = value;
                    smm_pkg::KIND_WR_B: b_mem[{row, col}] = value;
                    smm_pkg::KIND_COMP: form_product(half_reg);
                    default:            word = c_mem[{row, col}];
                endcase
                expected_results.push_back(word);
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: result %0d with no transaction pending",
                                 result_value);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (result_value !== want) begin
                        if (fail_count < 10)
                            $display("ERROR: result_value expected %0d, got %0d",
                                     $signed(want), result_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_results.size();
        end
    end
endmodule

>>> dv/strassen_block_matrix_multiply_top_tb.sv
`timescale 1ns / 1ps
module strassen_block_matrix_multiply_top_tb;
    localparam int CYCLE_LIMIT = 1500000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_value;
    int                 fail_count;
    int                 pending_count;

    // Stimulus-side bookkeeping: only reads of C entries some compute has produced.
    bit [255:0] c_ready_map;
    logic [3:0] half_now;
    int         burst_left;
    int         cycle_count = 0;

    strassen_block_matrix_multiply_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .row          (row),
        .col          (col),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

    strassen_block_matrix_multiply_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: rotate stall style as the cycle count advances - always ready, random
    // stalls, or one cycle in three.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            case ((cycle_count >> 9) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 6);
                default: out_ready <= (cycle_count % 3 == 0);
            endcase
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly random words, with the signed extremes, -1 and zero mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Present one transaction and hold it until accepted; call at a clock edge.
    // Between bursts drop valid for a random gap.
    task automatic send(input logic [1:0] k, input logic [3:0] r, input logic [3:0] c,
                        input logic [31:0] v);
        int h;
        in_valid <= 1'b1;
        kind     <= k;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == smm_pkg::KIND_COMP)
        begin
            h = (half_now == 0) ? 1 : ((half_now > 8) ? 8 : int'(half_now));
            for (int i = 0; i < 2*h; i++)
                for (int j = 0; j < 2*h; j++)
                    c_ready_map[i*16 + j] = 1'b1;
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    task automatic read_c();
        logic [3:0] r;
        logic [3:0] c;
        do
        begin
            r = 4'($urandom_range(0, 15));
            c = 4'($urandom_range(0, 15));
        end
        while (!c_ready_map[{r, c}]);
        send(smm_pkg::KIND_RD_C, r, c, $urandom);
    endtask

    // Hold off the sender until every result is back, plus a margin.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_half(input logic [3:0] hs);
        cfg_we    <= 1'b1;
        cfg_wdata <= hs;
        half_now  = hs;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    logic [3:0] half_plan [18] = '{4'd2, 4'd3, 4'd1, 4'd4, 4'd0, 4'd5, 4'd15, 4'd2, 4'd6,
                                   4'd3, 4'd7, 4'd1, 4'd9, 4'd2, 4'd8, 4'd3, 4'd1, 4'd2};

    initial
    begin
        int computes;
        int sel;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        kind        = smm_pkg::KIND_WR_A;
        row         = '0;
        col         = '0;
        value       = '0;
        c_ready_map = '0;
        half_now    = smm_pkg::HALF_RESET;
        burst_left  = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every A and B entry at the reset half size, so any later size is legal.
        for (int i = 0; i < 256; i++)
            send(smm_pkg::KIND_WR_A, i[7:4], i[3:0], pick_word());
        for (int i = 0; i < 256; i++)
            send(smm_pkg::KIND_WR_B, i[7:4], i[3:0], pick_word());
        send(smm_pkg::KIND_COMP, 4'd0, 4'd0, 32'd0);
        for (int i = 0; i < 30; i++)
            read_c();
        drain();

        // Directed: smallest size with extreme operands, then half size zero
        // (acts as one) and an oversized value (saturates to eight).
        write_half(4'd1);
        send(smm_pkg::KIND_WR_A, 4'd0, 4'd0, 32'h8000_0000);
        send(smm_pkg::KIND_WR_A, 4'd0, 4'd1, 32'h7fff_ffff);
        send(smm_pkg::KIND_WR_A, 4'd1, 4'd0, 32'hffff_ffff);
        send(smm_pkg::KIND_WR_A, 4'd1, 4'd1, 32'h0000_0000);
        send(smm_pkg::KIND_WR_B, 4'd0, 4'd0, 32'h7fff_ffff);
        send(smm_pkg::KIND_WR_B, 4'd0, 4'd1, 32'h8000_0000);
        send(smm_pkg::KIND_WR_B, 4'd1, 4'd0, 32'h0000_0000);
        send(smm_pkg::KIND_WR_B, 4'd1, 4'd1, 32'hffff_ffff);
        send(smm_pkg::KIND_COMP, 4'd0, 4'd0, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd0, 4'd0, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd0, 4'd1, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd1, 4'd0, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd1, 4'd1, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd15, 4'd15, 32'd0);
        drain();
        write_half(4'd0);
        send(smm_pkg::KIND_WR_A, 4'd15, 4'd15, 32'h7fff_ffff);
        send(smm_pkg::KIND_COMP, 4'd0, 4'd0, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd1, 4'd1, 32'd0);
        drain();
        write_half(4'd15);
        send(smm_pkg::KIND_COMP, 4'd0, 4'd0, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd15, 4'd15, 32'd0);
        send(smm_pkg::KIND_RD_C, 4'd0, 4'd0, 32'd0);
        drain();

        // Random phases: writes anywhere, reads of produced entries, and few
        // computes at large sizes to keep the run short.
        foreach (half_plan[p])
        begin
            write_half(half_plan[p]);
            computes = 0;
            for (int n = 0; n < 40; n++)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 5)
                    send(smm_pkg::KIND_WR_A, 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), pick_word());
                else if (sel < 10)
                    send(smm_pkg::KIND_WR_B, 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), pick_word());
                else if (sel < 12 && (half_now < 6 || half_now == 0 || computes == 0))
                begin
                    send(smm_pkg::KIND_COMP, 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), $urandom);
                    computes++;
                end
                else
                    read_c();
            end
            drain();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/smm_pkg.sv
rtl/smm_mem.sv
rtl/strassen_block_matrix_multiply_top.sv
dv/strassen_block_matrix_multiply_checker.sv
dv/strassen_block_matrix_multiply_top_tb.sv
